[rtl/pgtr_pkg.sv]
// pgtr_pkg: types, sizes and codes shared by the glyph text renderer
// no dependencies; used by every module of the renderer
`timescale 1ns / 1ps

package pgtr_pkg;

    // font store geometry
    localparam int NUM_GLYPHS       = 128;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int MAX_GLYPH_WIDTH  = 32;
    localparam int CODE_W           = $clog2(NUM_GLYPHS);
    localparam int ROW_W            = $clog2(MAX_GLYPH_HEIGHT);
    localparam int ROW_ADDR_W       = CODE_W + ROW_W;
    localparam int COORD_MAX        = 4095;

    // command queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);

    // op codes of an input word
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_DRAW   = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;

    // configuration register indexes
    localparam logic [7:0] REG_GLYPH_HEIGHT = 8'd0;
    localparam logic [7:0] REG_WRAP_WIDTH   = 8'd1;

    // input word
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [4:0]  row_index;
        logic [31:0] row_bits;
        logic [5:0]  glyph_width;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [15:0] color;
    } t_in;

    // result word
    typedef struct packed {
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [31:0] row_mask;
        logic [5:0]  row_width;
        logic [15:0] out_color;
        logic        last;
    } t_out;

    // configuration registers
    typedef struct packed {
        logic [5:0]  glyph_height;
        logic [11:0] wrap_width;
    } t_cfg;

    // classified command kinds
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_DRAW,
        KIND_CURSOR
    } t_kind;

    // queued command after classification
    typedef struct packed {
        t_kind                 kind;
        logic [CODE_W-1:0]     code;
        logic [ROW_W-1:0]      row;
        logic [31:0]           bits;
        logic [5:0]            width;
        logic [11:0]           pos_x;
        logic [11:0]           pos_y;
        logic [15:0]           color;
    } t_cmd;

    // queue head toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

[rtl/pgtr_front.sv]
// pgtr_front: accepts input words, drops those without effect, queues the rest
// depends on pgtr_pkg
`timescale 1ns / 1ps

module pgtr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pgtr_pkg::t_in   i_item,
    input  logic            i_pop,
    output pgtr_pkg::t_head o_head
);

    pgtr_pkg::t_cmd            r_q [pgtr_pkg::FQ_DEPTH];
    logic [pgtr_pkg::FQ_AW-1:0] r_wr, n_wr;
    logic [pgtr_pkg::FQ_AW-1:0] r_rd, n_rd;
    logic [pgtr_pkg::FQ_AW:0]   r_cnt, n_cnt;
    logic                       keep;
    logic                       code_ok;
    logic                       push;
    logic                       pop;
    pgtr_pkg::t_cmd             cmd;

    // classify the incoming word
    always_comb begin
        code_ok = ({1'b0, i_item.char_code} < 9'(pgtr_pkg::NUM_GLYPHS));
        cmd.code  = i_item.char_code[pgtr_pkg::CODE_W-1:0];
        cmd.row   = i_item.row_index[pgtr_pkg::ROW_W-1:0];
        cmd.bits  = i_item.row_bits;
        cmd.width = (i_item.glyph_width > 6'(pgtr_pkg::MAX_GLYPH_WIDTH))
                    ? 6'(pgtr_pkg::MAX_GLYPH_WIDTH) : i_item.glyph_width;
        cmd.pos_x = i_item.pos_x;
        cmd.pos_y = i_item.pos_y;
        cmd.color = i_item.color;
        cmd.kind  = pgtr_pkg::KIND_LOAD;
        keep      = 1'b0;
        case (i_item.op)
            pgtr_pkg::OP_LOAD: begin
                cmd.kind = pgtr_pkg::KIND_LOAD;
                keep     = code_ok;
            end
            pgtr_pkg::OP_DRAW: begin
                cmd.kind = pgtr_pkg::KIND_DRAW;
                keep     = code_ok;
            end
            pgtr_pkg::OP_CURSOR: begin
                cmd.kind = pgtr_pkg::KIND_CURSOR;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // queue control
    always_comb begin
        busy  = (r_cnt == (pgtr_pkg::FQ_AW+1)'(pgtr_pkg::FQ_DEPTH));
        push  = start && !busy && keep;
        pop   = i_pop && (r_cnt != '0);
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (pgtr_pkg::FQ_AW+1)'(push) - (pgtr_pkg::FQ_AW+1)'(pop);
        o_head.valid = (r_cnt != '0);
        o_head.cmd   = r_q[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

endmodule

[rtl/pgtr_back.sv]
// pgtr_back: glyph store, cursor and row sequencer that emits drawn rows
// depends on pgtr_pkg
`timescale 1ns / 1ps

module pgtr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pgtr_pkg::t_cfg  i_cfg,
    input  pgtr_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_res_valid,
    output pgtr_pkg::t_out  o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WRAP = 3'b010,
        S_ROW  = 3'b100
    } t_state;

    // saturating coordinate add
    function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [5:0] b);
        logic [12:0] s;
        s = {1'b0, a} + {7'd0, b};
        return (s > 13'(pgtr_pkg::COORD_MAX)) ? 12'(pgtr_pkg::COORD_MAX) : s[11:0];
    endfunction

    // mask of the low w columns
    function automatic logic [31:0] width_mask(input logic [5:0] w);
        return (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    endfunction

    t_state                              r_state, n_state;
    logic [pgtr_pkg::CODE_W-1:0]         r_code, n_code;
    logic [15:0]                         r_color, n_color;
    logic [11:0]                         r_cur_x, n_cur_x;
    logic [11:0]                         r_cur_y, n_cur_y;
    logic [5:0]                          r_w, n_w;
    logic [31:0]                         r_mask, n_mask;
    logic [5:0]                          r_h, n_h;
    logic [pgtr_pkg::ROW_W-1:0]          r_i, n_i;
    logic                                r_out_valid, n_out_valid;
    pgtr_pkg::t_out                      r_out, n_out;

    // glyph stores
    logic [31:0]                         r_rows [1 << pgtr_pkg::ROW_ADDR_W];
    logic [5:0]                          r_wmem [pgtr_pkg::NUM_GLYPHS];
    logic [pgtr_pkg::NUM_GLYPHS-1:0]     r_wvalid;
    logic [31:0]                         r_row_rd;
    logic [5:0]                          r_w_rd;
    logic                                r_w_rd_vld;

    logic                                row_we;
    logic                                w_we;
    logic [pgtr_pkg::ROW_ADDR_W-1:0]     row_wa;
    logic [pgtr_pkg::ROW_ADDR_W-1:0]     row_ra;
    logic [pgtr_pkg::CODE_W-1:0]         w_addr;

    logic [5:0]                          g_w;
    logic [5:0]                          g_h;
    logic [12:0]                         x_sum;
    logic                                wrap;
    logic [11:0]                         base_x;
    logic                                is_last;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_color     = r_color;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_w         = r_w;
        n_mask      = r_mask;
        n_h         = r_h;
        n_i         = r_i;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_pop       = 1'b0;
        row_we      = 1'b0;
        w_we        = 1'b0;
        row_wa      = {i_head.cmd.code, i_head.cmd.row};
        w_addr      = i_head.cmd.code;
        row_ra      = {r_code, r_i + 1'b1};

        g_w     = r_w_rd_vld ? r_w_rd : 6'd0;
        g_h     = (i_cfg.glyph_height > 6'(pgtr_pkg::MAX_GLYPH_HEIGHT))
                  ? 6'(pgtr_pkg::MAX_GLYPH_HEIGHT) : i_cfg.glyph_height;
        x_sum   = {1'b0, r_cur_x} + {7'd0, g_w};
        wrap    = (x_sum > {1'b0, i_cfg.wrap_width});
        base_x  = wrap ? 12'd0 : r_cur_x;
        is_last = ({1'b0, r_i} + 6'd1 == r_h);

        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.cmd.kind)
                        pgtr_pkg::KIND_LOAD: begin
                            w_we   = 1'b1;
                            row_we = ({1'b0, i_head.cmd.row}
                                      < (pgtr_pkg::ROW_W+1)'(pgtr_pkg::MAX_GLYPH_HEIGHT));
                        end
                        pgtr_pkg::KIND_CURSOR: begin
                            n_cur_x = i_head.cmd.pos_x;
                            n_cur_y = i_head.cmd.pos_y;
                        end
                        pgtr_pkg::KIND_DRAW: begin
                            n_code  = i_head.cmd.code;
                            n_color = i_head.cmd.color;
                            n_state = S_WRAP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRAP: begin
                // width is back from the store: wrap, then fetch row 0
                row_ra  = {r_code, {pgtr_pkg::ROW_W{1'b0}}};
                n_cur_y = wrap ? sat_add(r_cur_y, g_h) : r_cur_y;
                n_w     = g_w;
                n_mask  = width_mask(g_w);
                n_h     = g_h;
                n_i     = '0;
                if (g_h == 6'd0) begin
                    n_cur_x = sat_add(base_x, g_w);
                    n_state = S_IDLE;
                end else begin
                    n_cur_x = base_x;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                // one glyph row out per cycle
                n_out_valid     = 1'b1;
                n_out.out_x     = r_cur_x;
                n_out.out_y     = sat_add(r_cur_y, {1'b0, r_i});
                n_out.row_mask  = r_row_rd & r_mask;
                n_out.row_width = r_w;
                n_out.out_color = r_color;
                n_out.last      = is_last;
                if (is_last) begin
                    n_cur_x = sat_add(r_cur_x, r_w);
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_out_valid <= 1'b0;
            r_wvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_out_valid <= n_out_valid;
            if (w_we) begin
                r_wvalid[w_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_color <= n_color;
        r_w     <= n_w;
        r_mask  <= n_mask;
        r_h     <= n_h;
        r_i     <= n_i;
        r_out   <= n_out;
    end

    // glyph row store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_rows[row_wa] <= i_head.cmd.bits;
        end
        r_row_rd <= r_rows[row_ra];
    end

    // glyph width store, never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_addr] <= i_head.cmd.width;
        end
        r_w_rd     <= r_wmem[w_addr];
        r_w_rd_vld <= r_wvalid[w_addr];
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

[rtl/proportional_glyph_text_renderer.sv]
// proportional_glyph_text_renderer: top level, configuration registers and checks
// depends on pgtr_pkg, pgtr_front, pgtr_back
`timescale 1ns / 1ps

// Words are taken while busy is low; a four-deep command queue sits in front
// of the executing back end, so busy rises only when that queue is full.
// In the back end a glyph load or a cursor set is handled in the idle state,
// and a draw emits min(glyph_height, 32) rows: the idle state reads the glyph
// width, S_WRAP wraps the cursor and fetches row 0, then S_ROW sends one row
// per cycle from the single read port of the glyph row store. Words
// with an unknown op, and loads or draws of codes above 127, are dropped at
// the front. Each drawn row appears on o_res for exactly one cycle with
// o_res_valid high and cannot be held off; rows of one glyph come in
// consecutive cycles. The configuration channel is always ready; write it
// only while idle.
module proportional_glyph_text_renderer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pgtr_pkg::t_in  i_item,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_index,
    input  logic [11:0]    i_cfg_data,
    output logic           o_res_valid,
    output pgtr_pkg::t_out o_res
);

    pgtr_pkg::t_cfg  r_cfg;
    pgtr_pkg::t_head head;
    logic            pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_height <= 6'd8;
            r_cfg.wrap_width   <= 12'd640;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pgtr_pkg::REG_GLYPH_HEIGHT: r_cfg.glyph_height <= i_cfg_data[5:0];
                pgtr_pkg::REG_WRAP_WIDTH:   r_cfg.wrap_width   <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    pgtr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_head  (head)
    );

    pgtr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef ASSERT_OFF
    // a glyph's last row is never followed directly by another result
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("result right after a glyph's last row");

    // rows of one glyph come back to back at the same column and width
    a_rows_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |=> (o_res_valid
            && o_res.out_x == $past(o_res.out_x)
            && o_res.row_width == $past(o_res.row_width)))
        else $error("glyph rows split or moved");

    // row position steps down by one until it saturates
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last && o_res.out_y != 12'(pgtr_pkg::COORD_MAX))
        |=> (o_res.out_y == $past(o_res.out_y) + 12'd1))
        else $error("glyph row position did not advance");
`endif

endmodule
